/* sv/ssnv_pkg.sv */
// ----------------------------------------------------------------------------
// ssnv_pkg
// Shared types and constants for the sorted set nearest value block.
// ----------------------------------------------------------------------------
package ssnv_pkg;

  localparam int Depth  = 1024;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_Q_RD_LO,
    S_Q_RD_HI,
    S_Q_CMP,
    S_OUT
  } state_t;

endpackage

/* sv/ssnv_if.sv */
// ----------------------------------------------------------------------------
// ssnv_in_if / ssnv_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ssnv_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [31:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface ssnv_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] nearest;
  modport source (output valid, status, nearest, input ready);
  modport sink   (input valid, status, nearest, output ready);
endinterface

/* sv/ssnv_ram.sv */
// ----------------------------------------------------------------------------
// ssnv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ssnv_ram #(
  parameter int Width = 32,
  parameter int Words = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Words)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Words];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/sorted_set_nearest_value_top.sv */
// ----------------------------------------------------------------------------
// sorted_set_nearest_value_top
// Sorted store of signed values with insert, clear and nearest-value query.
// ----------------------------------------------------------------------------
// channel  dir  payload                      beat
// in       in   cmd[1:0], value[31:0]        one command
// out      out  status[1:0], nearest[31:0]   one result per command
//
// Query: binary search (log2(n)+1 probes), then the neighbouring entries are read.
// Insert: search, then entries are moved up one at a time through the single RAM
// port. Reset empties the set at once. The result register holds under a stall;
// a new command waits until it leaves.
// ----------------------------------------------------------------------------
module sorted_set_nearest_value_top
  import ssnv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  ssnv_in_if.sink    in_ch,
  ssnv_out_if.source out_ch
);
  state_t state, state_next;
  logic [CountW-1:0] count, count_next;
  logic [CountW-1:0] lo, lo_next, hi, hi_next, ptr, ptr_next;
  cmd_t cmd, cmd_next;
  logic signed [31:0] key, key_next, lo_val, lo_val_next;
  logic [1:0] status_r, status_next;
  logic signed [31:0] near_r, near_next;
  logic out_valid, out_valid_next;

  logic               we;
  logic [AddrW-1:0]   addr;
  logic [31:0]        wdata, rdata;
  logic [CountW-1:0]  mid;
  logic signed [32:0] above, below;

  ssnv_ram #(.Width(32), .Words(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  assign mid   = lo + ((hi - lo) >> 1);
  assign above = 33'(signed'(rdata)) - 33'(key);
  assign below = 33'(key) - 33'(lo_val);

  assign in_ch.ready    = !rst && (state == S_IDLE) && !out_valid;
  assign out_ch.valid   = out_valid;
  assign out_ch.status  = status_r;
  assign out_ch.nearest = near_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    lo <= lo_next; hi <= hi_next; ptr <= ptr_next;
    cmd <= cmd_next; key <= key_next; lo_val <= lo_val_next;
    status_r <= status_next; near_r <= near_next;
  end

  always_comb begin
    state_next = state; count_next = count;
    lo_next = lo; hi_next = hi; ptr_next = ptr;
    cmd_next = cmd; key_next = key; lo_val_next = lo_val;
    status_next = status_r; near_next = near_r;
    out_valid_next = out_valid;
    we = 1'b0; addr = '0; wdata = '0;
    if (out_valid && out_ch.ready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          cmd_next = cmd_t'(in_ch.cmd);
          key_next = in_ch.value;
          status_next = ST_OK;
          near_next = '0;
          lo_next = '0;
          hi_next = count;
          state_next = S_OUT;
          case (cmd_t'(in_ch.cmd))
            CMD_CLEAR:  count_next = '0;
            CMD_INSERT: begin
              if (count == CountW'(Depth)) status_next = ST_FULL;
              else state_next = S_SRCH_RD;
            end
            CMD_QUERY: begin
              if (count == '0) status_next = ST_EMPTY;
              else state_next = S_SRCH_RD;
            end
            default: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (lo < hi) begin
          addr = mid[AddrW-1:0];
          state_next = S_SRCH_CMP;
        end else if (cmd == CMD_INSERT) begin
          ptr_next = count;
          state_next = S_SHIFT_RD;
        end else if (lo == '0 || lo == count) begin
          addr = (lo == '0) ? '0 : AddrW'(count - 1'b1);
          state_next = S_Q_RD_HI;
        end else begin
          addr = AddrW'(lo - 1'b1);
          state_next = S_Q_RD_LO;
        end
      end
      S_SRCH_CMP: begin
        if (signed'(rdata) > key) hi_next = mid;
        else lo_next = mid + 1'b1;
        state_next = S_SRCH_RD;
      end
      S_SHIFT_RD: begin
        if (ptr == lo) state_next = S_INS_WR;
        else begin
          addr = AddrW'(ptr - 1'b1);
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; addr = ptr[AddrW-1:0]; wdata = rdata;
        ptr_next = ptr - 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_INS_WR: begin
        we = 1'b1; addr = lo[AddrW-1:0]; wdata = key;
        count_next = count + 1'b1;
        state_next = S_OUT;
      end
      S_Q_RD_LO: begin
        lo_val_next = signed'(rdata);
        addr = lo[AddrW-1:0];
        state_next = S_Q_CMP;
      end
      S_Q_RD_HI: begin
        near_next = signed'(rdata);
        state_next = S_OUT;
      end
      S_Q_CMP: begin
        near_next = (above > below) ? lo_val : signed'(rdata);
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* tb/sv/sorted_set_nearest_value_top_tb.sv */
// ----------------------------------------------------------------------------
// sorted_set_nearest_value_top_tb
// Drives clear, insert and query commands into the sorted set and checks
// every result against a queue-based sorted-set predictor.
// ----------------------------------------------------------------------------
module sorted_set_nearest_value_top_tb;
  import ssnv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] nearest;
  } nearest_result_t;

  class nearest_scoreboard;
    logic signed [31:0] set_values[$];
    nearest_result_t    pending[$];
    int                 errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_command(cmd_t cmd, logic signed [31:0] value);
      nearest_result_t r;
      int lo, hi, mid;
      longint above, below;
      r.status = ST_OK;
      r.nearest = '0;
      case (cmd)
        CMD_CLEAR: begin
          set_values.delete();
        end
        CMD_INSERT: begin
          if (set_values.size() >= Depth) begin
            r.status = ST_FULL;
          end else begin
            lo = 0;
            hi = set_values.size();
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (set_values[mid] > value) hi = mid;
              else lo = mid + 1;
            end
            set_values.insert(lo, value);
          end
        end
        CMD_QUERY: begin
          if (set_values.size() == 0) begin
            r.status = ST_EMPTY;
          end else if (value <= set_values[0]) begin
            r.nearest = set_values[0];
          end else if (value >= set_values[$]) begin
            r.nearest = set_values[$];
          end else begin
            lo = 0;
            hi = set_values.size();
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (set_values[mid] > value) hi = mid;
              else lo = mid + 1;
            end
            above = longint'(set_values[lo]) - longint'(value);
            below = longint'(value) - longint'(set_values[lo - 1]);
            r.nearest = (above > below) ? set_values[lo - 1] : set_values[lo];
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(logic [1:0] status, logic signed [31:0] nearest);
      nearest_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d nearest=%0d",
                                  status, nearest));
        return;
      end
      e = pending.pop_front();
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", status, e.status));
      if (nearest !== e.nearest)
        report_mismatch($sformatf("nearest %0d, want %0d", nearest, e.nearest));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  nearest_scoreboard sb = new();

  ssnv_in_if  in_ch();
  ssnv_out_if out_ch();

  sorted_set_nearest_value_top uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.nearest);
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_beat(cmd_t cmd, logic signed [31:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, value);
  endtask

  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(40)) - 20;
      2: return 32'sh7fffffff - $urandom_range(3);
      default: return 32'sh80000000 + $urandom_range(3);
    endcase
  endfunction

  task automatic run_random(int count);
    int  r, fill;
    logic signed [31:0] v;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      v = pick_value($urandom_range(3));
      if (r < 3) send_beat(CMD_CLEAR, $urandom());
      else if (r < 5) send_beat(CMD_NONE, $urandom());
      else if (r < 45) send_beat(CMD_INSERT, v);
      else send_beat(CMD_QUERY, v);
      if (r == 99 && sb.set_values.size() < 40) begin
        fill = $urandom_range(8);
        for (int k = 0; k < fill; k++) send_beat(CMD_INSERT, pick_value(1));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(CMD_QUERY, 32'sd5);
    send_beat(CMD_INSERT, 32'sd0);
    send_beat(CMD_QUERY, 32'sh80000000);
    send_beat(CMD_INSERT, 32'sh7fffffff);
    send_beat(CMD_INSERT, 32'sh80000000);
    send_beat(CMD_QUERY, 32'sh7fffffff);
    send_beat(CMD_QUERY, 32'sh3fffffff);
    send_beat(CMD_QUERY, 32'sh40000000);
    send_beat(CMD_QUERY, 32'shc0000000);
    send_beat(CMD_QUERY, 32'shbfffffff);
    send_beat(CMD_NONE, 32'shffffffff);
    send_beat(CMD_INSERT, 32'sd10);
    send_beat(CMD_INSERT, 32'sd10);
    send_beat(CMD_INSERT, 32'sd20);
    send_beat(CMD_QUERY, 32'sd15);
    send_beat(CMD_QUERY, 32'sd14);
    send_beat(CMD_CLEAR, 32'sd0);
    send_beat(CMD_QUERY, 32'sd0);
    send_beat(CMD_INSERT, 32'sd3);
    send_beat(CMD_QUERY, -32'sd3);
    send_beat(CMD_CLEAR, 32'sd0);

    src_idle_pct = 17; snk_idle_pct = 65;
    run_random(300);
    src_idle_pct = 65; snk_idle_pct = 17;
    run_random(300);
    src_idle_pct = 0; snk_idle_pct = 0;
    run_random(300);
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS sorted_set_nearest_value_top");
    else $display("FAIL sorted_set_nearest_value_top");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL sorted_set_nearest_value_top");
    $finish;
  end
endmodule
